// ===== hw/rtl/lap_position_event_sequencer_assert.svh =====
// assertion macros shared by the sequencer rtl
// expects clk and arst_n in the scope of each use
`ifndef LAP_POSITION_EVENT_SEQUENCER_ASSERT_SVH
`define LAP_POSITION_EVENT_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define LPES_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LPES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LPES_ASSERT_IMPL(lbl, ante, cons, msg)
`define LPES_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lpes_pkg.sv =====
// shared types, micro-op and condition codes for the event sequencer
// no dependencies
`default_nettype none
package lpes_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int DIST_BITS_DEF   = 16;

	localparam int OP_W   = 4;
	localparam int COND_W = 4;
	localparam int PC_W   = 5;

	// micro-ops
	localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
	localparam logic [OP_W-1:0] OP_NORM       = 4'd1;
	localparam logic [OP_W-1:0] OP_LAPTEST    = 4'd2;
	localparam logic [OP_W-1:0] OP_SCAN_INIT  = 4'd3;
	localparam logic [OP_W-1:0] OP_SCAN_RD    = 4'd4;
	localparam logic [OP_W-1:0] OP_SCAN_APPLY = 4'd5;
	localparam logic [OP_W-1:0] OP_REWIND     = 4'd6;
	localparam logic [OP_W-1:0] OP_READ_PEND  = 4'd7;
	localparam logic [OP_W-1:0] OP_EVT_APPLY  = 4'd8;
	localparam logic [OP_W-1:0] OP_LAP_END    = 4'd9;
	localparam logic [OP_W-1:0] OP_PIT_REWIND = 4'd10;
	localparam logic [OP_W-1:0] OP_PIT_SET    = 4'd11;
	localparam logic [OP_W-1:0] OP_WRITE      = 4'd12;
	localparam logic [OP_W-1:0] OP_FINISH     = 4'd13;

	// jump conditions
	localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
	localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
	localparam logic [COND_W-1:0] C_IS_LOAD    = 4'd2;
	localparam logic [COND_W-1:0] C_IS_PIT     = 4'd3;
	localparam logic [COND_W-1:0] C_WAS_PIT    = 4'd4;
	localparam logic [COND_W-1:0] C_WAIT       = 4'd5;
	localparam logic [COND_W-1:0] C_NOT_WRAP   = 4'd6;
	localparam logic [COND_W-1:0] C_NOT_PASSED = 4'd7;
	localparam logic [COND_W-1:0] C_PEND_END   = 4'd8;
	localparam logic [COND_W-1:0] C_NOT_ONLY   = 4'd9;
	localparam logic [COND_W-1:0] C_SCAN_END   = 4'd10;

	// result kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_STOP  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// configuration register indexes
	localparam logic REG_EVENT_COUNT = 1'b0;
	localparam logic REG_WRAP_THR    = 1'b1;

	localparam logic [4:0]         EVENT_COUNT_RST = 5'd1;
	localparam logic signed [16:0] WRAP_THR_RST    = -17'sd1000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} lpes_uword_t;

	// datapath flags seen by the sequencer
	typedef struct packed {
		logic is_load;
		logic is_pit;
		logic was_pit;
		logic waiting;
		logic wrap;
		logic passed;
		logic pend_end;
		logic scan_end;
		logic only_one;
	} lpes_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lpes_ctrl.sv =====
// microcode sequencer: program rom, step counter and jump logic
// depends on lpes_pkg and the assertion macro header
`default_nettype none
`include "lap_position_event_sequencer_assert.svh"
module lpes_ctrl
	import lpes_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start_acc,
	input  wire lpes_stat_t      stat,
	output logic [OP_W-1:0]      op,
	output logic                 busy
);

	localparam logic [PC_W-1:0] L_SCAN_A = 5'd8;
	localparam logic [PC_W-1:0] L_LOOP   = 5'd9;
	localparam logic [PC_W-1:0] L_TEST   = 5'd10;
	localparam logic [PC_W-1:0] L_FIN    = 5'd14;
	localparam logic [PC_W-1:0] L_END    = 5'd15;
	localparam logic [PC_W-1:0] L_PIT    = 5'd19;
	localparam logic [PC_W-1:0] L_PIT_B  = 5'd23;
	localparam logic [PC_W-1:0] L_PIT_C  = 5'd24;
	localparam logic [PC_W-1:0] L_LOAD   = 5'd25;

	function automatic lpes_uword_t rom_word(input logic [PC_W-1:0] a);
		lpes_uword_t w;
		w = '{op: OP_FINISH, cond: C_NEVER, target: L_FIN};
		case (a)
			5'd0:  w = '{op: OP_NOP,        cond: C_IS_LOAD,    target: L_LOAD};
			5'd1:  w = '{op: OP_NORM,       cond: C_IS_PIT,     target: L_PIT};
			5'd2:  w = '{op: OP_LAPTEST,    cond: C_NEVER,      target: L_FIN};
			5'd3:  w = '{op: OP_NOP,        cond: C_WAIT,       target: L_FIN};
			5'd4:  w = '{op: OP_NOP,        cond: C_NOT_WRAP,   target: L_LOOP};
			// stop pass after a new lap
			5'd5:  w = '{op: OP_SCAN_INIT,  cond: C_NEVER,      target: L_FIN};
			5'd6:  w = '{op: OP_SCAN_RD,    cond: C_SCAN_END,   target: L_SCAN_A};
			5'd7:  w = '{op: OP_SCAN_APPLY, cond: C_ALWAYS,     target: 5'd6};
			5'd8:  w = '{op: OP_REWIND,     cond: C_NEVER,      target: L_FIN};
			// event walk
			5'd9:  w = '{op: OP_READ_PEND,  cond: C_NEVER,      target: L_FIN};
			5'd10: w = '{op: OP_NOP,        cond: C_NOT_PASSED, target: L_FIN};
			5'd11: w = '{op: OP_EVT_APPLY,  cond: C_NEVER,      target: L_FIN};
			5'd12: w = '{op: OP_READ_PEND,  cond: C_PEND_END,   target: L_END};
			5'd13: w = '{op: OP_NOP,        cond: C_NOT_ONLY,   target: L_TEST};
			5'd14: w = '{op: OP_FINISH,     cond: C_NEVER,      target: L_FIN};
			// table exhausted: rewind, wait, stop everything
			5'd15: w = '{op: OP_LAP_END,    cond: C_NEVER,      target: L_FIN};
			5'd16: w = '{op: OP_SCAN_INIT,  cond: C_NEVER,      target: L_FIN};
			5'd17: w = '{op: OP_SCAN_RD,    cond: C_SCAN_END,   target: L_FIN};
			5'd18: w = '{op: OP_SCAN_APPLY, cond: C_ALWAYS,     target: 5'd17};
			// pit entry
			5'd19: w = '{op: OP_NOP,        cond: C_WAS_PIT,    target: L_PIT_C};
			5'd20: w = '{op: OP_SCAN_INIT,  cond: C_NEVER,      target: L_FIN};
			5'd21: w = '{op: OP_SCAN_RD,    cond: C_SCAN_END,   target: L_PIT_B};
			5'd22: w = '{op: OP_SCAN_APPLY, cond: C_ALWAYS,     target: 5'd21};
			5'd23: w = '{op: OP_PIT_REWIND, cond: C_NEVER,      target: L_FIN};
			5'd24: w = '{op: OP_PIT_SET,    cond: C_ALWAYS,     target: L_FIN};
			// table load
			5'd25: w = '{op: OP_WRITE,      cond: C_ALWAYS,     target: L_FIN};
			default: w = '{op: OP_FINISH,   cond: C_NEVER,      target: L_FIN};
		endcase
		return w;
	endfunction

	logic              running_q;
	logic [PC_W-1:0]   pc_q;
	lpes_uword_t       word;
	logic              hit;

	assign word = rom_word(pc_q);
	assign op   = running_q ? word.op : OP_NOP;
	assign busy = running_q;

	always_comb begin
		case (word.cond)
			C_NEVER:      hit = 1'b0;
			C_ALWAYS:     hit = 1'b1;
			C_IS_LOAD:    hit = stat.is_load;
			C_IS_PIT:     hit = stat.is_pit;
			C_WAS_PIT:    hit = stat.was_pit;
			C_WAIT:       hit = stat.waiting;
			C_NOT_WRAP:   hit = !stat.wrap;
			C_NOT_PASSED: hit = !stat.passed;
			C_PEND_END:   hit = stat.pend_end;
			C_NOT_ONLY:   hit = !stat.only_one;
			C_SCAN_END:   hit = stat.scan_end;
			default:      hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			pc_q      <= '0;
		end else if (start_acc) begin
			running_q <= 1'b1;
			pc_q      <= '0;
		end else if (running_q) begin
			if (word.op == OP_FINISH) begin
				running_q <= 1'b0;
			end
			pc_q <= hit ? word.target : pc_q + PC_W'(1);
		end
	end

	`LPES_ASSERT_NEXT(a_start_runs, start_acc, running_q && pc_q == '0, "start not taken up")
	`LPES_ASSERT_NEXT(a_finish_halts, running_q && word.op == OP_FINISH, !running_q,
		"sequencer kept running after finish")
	`LPES_ASSERT_IMPL(a_idle_start, start_acc, !running_q, "start taken while running")

endmodule
`default_nettype wire

// ===== hw/rtl/lpes_dpath.sv =====
// datapath: event table, tick state, configuration and result register
// depends on lpes_pkg and the assertion macro header
`default_nettype none
`include "lap_position_event_sequencer_assert.svh"
module lpes_dpath
	import lpes_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int DIST_BITS   = DIST_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [16:0]           cfg_wdata,
	input  wire logic                  start_acc,
	input  wire logic                  cmd,
	input  wire logic [DIST_BITS-1:0]  lap_distance,
	input  wire logic                  on_pit_road,
	input  wire logic [3:0]            entry_index,
	input  wire logic [DIST_BITS-1:0]  entry_distance,
	input  wire logic                  entry_is_stop,
	input  wire logic [3:0]            entry_pair,
	input  wire logic [OP_W-1:0]       op,
	output lpes_stat_t                 stat,
	output logic                       result_valid,
	output logic [1:0]                 kind,
	output logic [3:0]                 pair,
	output logic [15:0]                active_mask,
	output logic [3:0]                 next_index,
	output logic                       waiting,
	output logic                       last
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = (DIST_BITS + 1 > 17) ? DIST_BITS + 2 : 18;
	localparam int EW = DIST_BITS + 5;

	// table memory: {distance, is_stop, pair}
	logic [EW-1:0]         ev_mem_q [TABLE_DEPTH];
	logic [EW-1:0]         rd_q;
	logic [IW-1:0]         rd_addr;
	logic [DIST_BITS-1:0]  rd_dist;
	logic                  rd_stop;
	logic [3:0]            rd_pair;

	// captured input item
	logic                  cmd_q;
	logic [DIST_BITS-1:0]  dist_q;
	logic                  pit_in_q;
	logic [3:0]            eidx_q;
	logic [DIST_BITS-1:0]  edist_q;
	logic                  estop_q;
	logic [3:0]            epair_q;

	// configuration
	logic [4:0]            ev_count_q;
	logic signed [16:0]    wrap_thr_q;

	// tick state
	logic [CW-1:0]         pend_q, pend_nxt;
	logic                  wait_q, wait_nxt;
	logic [DIST_BITS-1:0]  prev_q, prev_nxt;
	logic                  pit_q, pit_nxt;
	logic [15:0]           act_q, act_nxt;
	logic [CW-1:0]         scan_q, scan_nxt;
	logic                  wrap_q, wrap_nxt;
	logic                  only_q, only_nxt;

	logic [CW-1:0]         cnt;
	logic signed [WW-1:0]  delta;
	logic signed [WW-1:0]  thr_ext;
	logic                  wrap_calc;

	logic                  emit;
	logic [1:0]            ekind;
	logic [3:0]            epair;
	logic                  elast;

	logic                  res_valid_q;
	logic [1:0]            kind_q;
	logic [3:0]            pair_q;
	logic [15:0]           mask_q;
	logic [3:0]            nidx_q;
	logic                  wait_o_q;
	logic                  last_q;

	assign rd_dist = rd_q[EW-1:5];
	assign rd_stop = rd_q[4];
	assign rd_pair = rd_q[3:0];

	// zero is taken as one, anything past the table as the table depth
	always_comb begin
		if (ev_count_q == 5'd0) begin
			cnt = CW'(1);
		end else if (32'(ev_count_q) > TABLE_DEPTH) begin
			cnt = CW'(TABLE_DEPTH);
		end else begin
			cnt = CW'(ev_count_q);
		end
	end

	assign delta     = $signed(WW'(dist_q)) - $signed(WW'(prev_q));
	assign thr_ext   = WW'(wrap_thr_q);
	assign wrap_calc = delta < thr_ext;

	assign rd_addr = (op == OP_SCAN_RD) ? scan_q[IW-1:0] : pend_q[IW-1:0];

	always_comb begin
		stat.is_load  = cmd_q;
		stat.is_pit   = pit_in_q;
		stat.was_pit  = pit_q;
		stat.waiting  = wait_q;
		stat.wrap     = wrap_q;
		stat.passed   = dist_q > rd_dist;
		stat.pend_end = pend_q >= cnt;
		stat.scan_end = scan_q >= cnt;
		stat.only_one = only_q;
	end

	always_comb begin
		pend_nxt = pend_q;
		wait_nxt = wait_q;
		prev_nxt = prev_q;
		pit_nxt  = pit_q;
		act_nxt  = act_q;
		scan_nxt = scan_q;
		wrap_nxt = wrap_q;
		only_nxt = only_q;
		emit     = 1'b0;
		ekind    = KIND_DONE;
		epair    = 4'd0;
		elast    = 1'b0;
		case (op)
			OP_NORM: begin
				if (pend_q >= cnt) begin
					pend_nxt = '0;
				end
				wrap_nxt = wrap_calc;
				only_nxt = wait_q;
			end
			OP_LAPTEST: begin
				pit_nxt = 1'b0;
				if (wait_q && wrap_q) begin
					wait_nxt = 1'b0;
				end
			end
			OP_SCAN_INIT: scan_nxt = pend_q;
			OP_SCAN_APPLY: begin
				if (rd_stop && act_q[rd_pair]) begin
					act_nxt[rd_pair] = 1'b0;
					emit  = 1'b1;
					ekind = KIND_STOP;
					epair = rd_pair;
				end
				scan_nxt = scan_q + CW'(1);
			end
			OP_REWIND: pend_nxt = '0;
			OP_EVT_APPLY: begin
				if (rd_stop) begin
					if (act_q[rd_pair]) begin
						act_nxt[rd_pair] = 1'b0;
						emit  = 1'b1;
						ekind = KIND_STOP;
						epair = rd_pair;
					end
				end else if (!act_q[rd_pair]) begin
					act_nxt[rd_pair] = 1'b1;
					emit  = 1'b1;
					ekind = KIND_START;
					epair = rd_pair;
				end
				pend_nxt = pend_q + CW'(1);
			end
			OP_LAP_END: begin
				pend_nxt = '0;
				wait_nxt = 1'b1;
			end
			OP_PIT_REWIND: begin
				pend_nxt = '0;
				wait_nxt = 1'b0;
			end
			OP_PIT_SET: pit_nxt = 1'b1;
			OP_FINISH: begin
				if (!cmd_q) begin
					prev_nxt = dist_q;
				end
				emit  = 1'b1;
				ekind = KIND_DONE;
				elast = 1'b1;
			end
			default: ;
		endcase
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (op == OP_WRITE && 32'(eidx_q) < TABLE_DEPTH) begin
			ev_mem_q[IW'(eidx_q)] <= {edist_q, estop_q, epair_q};
		end
		if (op == OP_SCAN_RD || op == OP_READ_PEND) begin
			rd_q <= ev_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			cmd_q    <= cmd;
			dist_q   <= lap_distance;
			pit_in_q <= on_pit_road;
			eidx_q   <= entry_index;
			edist_q  <= entry_distance;
			estop_q  <= entry_is_stop;
			epair_q  <= entry_pair;
		end
		scan_q <= scan_nxt;
		wrap_q <= wrap_nxt;
		only_q <= only_nxt;
		if (emit) begin
			kind_q   <= ekind;
			pair_q   <= epair;
			mask_q   <= act_nxt;
			nidx_q   <= 4'(pend_q);
			wait_o_q <= wait_q;
			last_q   <= elast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_count_q  <= EVENT_COUNT_RST;
			wrap_thr_q  <= WRAP_THR_RST;
			pend_q      <= '0;
			wait_q      <= 1'b0;
			prev_q      <= '0;
			pit_q       <= 1'b0;
			act_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_EVENT_COUNT) begin
				ev_count_q <= cfg_wdata[4:0];
			end
			if (cfg_we && cfg_index == REG_WRAP_THR) begin
				wrap_thr_q <= $signed(cfg_wdata);
			end
			pend_q      <= pend_nxt;
			wait_q      <= wait_nxt;
			prev_q      <= prev_nxt;
			pit_q       <= pit_nxt;
			act_q       <= act_nxt;
			res_valid_q <= emit;
		end
	end

	assign result_valid = res_valid_q;
	assign kind         = kind_q;
	assign pair         = pair_q;
	assign active_mask  = mask_q;
	assign next_index   = nidx_q;
	assign waiting      = wait_o_q;
	assign last         = last_q;

	`LPES_ASSERT_IMPL(a_last_is_done, res_valid_q && last_q, kind_q == KIND_DONE,
		"final result is not a done result")
	`LPES_ASSERT_IMPL(a_start_sets_bit, res_valid_q && kind_q == KIND_START, mask_q[pair_q],
		"started pair not shown active")
	`LPES_ASSERT_IMPL(a_stop_clears_bit, res_valid_q && kind_q == KIND_STOP, !mask_q[pair_q],
		"stopped pair still shown active")

endmodule
`default_nettype wire

// ===== hw/rtl/lap_position_event_sequencer.sv =====
// lap position event sequencer: top level
// depends on lpes_pkg, lpes_ctrl and lpes_dpath
// usage
//   - an item is taken when start is high and busy is low; cmd selects a
//     table load (slot, distance, start or stop flag, pair) or a position tick
//   - results come out one per cycle at most, each marked by result_valid for
//     a single cycle; the receiver cannot stall, so every strobe is a transfer
//   - each item ends with one done result that has last set; a tick gives
//     a start or stop result before that for every pair bit that changes
//   - configuration is written through cfg_we / cfg_index / cfg_wdata while
//     busy is low and no result is due
// timing
//   - one microcode step a cycle, table reads through one registered port
//   - a load runs a load test, the table write and the finish step; the done
//     result is registered by the finish step. A tick's work grows with the table:
//     stop passes read and apply entries; the walk reads, tests, applies events
//   - one item at a time; busy is high from the cycle after the transfer
//     until the final step
// reset: arst_n clears the pend, wait, prev and pit state, active pairs and
//   sequencer, restores config defaults; the table is undefined until loaded
`default_nettype none
module lap_position_event_sequencer
	import lpes_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int DIST_BITS   = DIST_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [16:0]           cfg_wdata,
	// command channel
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  cmd,
	input  wire logic [DIST_BITS-1:0]  lap_distance,
	input  wire logic                  on_pit_road,
	input  wire logic [3:0]            entry_index,
	input  wire logic [DIST_BITS-1:0]  entry_distance,
	input  wire logic                  entry_is_stop,
	input  wire logic [3:0]            entry_pair,
	// result channel
	output logic                       result_valid,
	output logic [1:0]                 kind,
	output logic [3:0]                 pair,
	output logic [15:0]                active_mask,
	output logic [3:0]                 next_index,
	output logic                       waiting,
	output logic                       last
);

	logic            start_acc;
	logic [OP_W-1:0] op;
	lpes_stat_t      stat;

	// command transfer
	assign start_acc = start && !busy;

	// sequencer steps through the rom and issues one micro-op a cycle
	lpes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_acc (start_acc),
		.stat      (stat),
		.op        (op),
		.busy      (busy)
	);

	// table, tick state and result register
	lpes_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.DIST_BITS   (DIST_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.start_acc      (start_acc),
		.cmd            (cmd),
		.lap_distance   (lap_distance),
		.on_pit_road    (on_pit_road),
		.entry_index    (entry_index),
		.entry_distance (entry_distance),
		.entry_is_stop  (entry_is_stop),
		.entry_pair     (entry_pair),
		.op             (op),
		.stat           (stat),
		.result_valid   (result_valid),
		.kind           (kind),
		.pair           (pair),
		.active_mask    (active_mask),
		.next_index     (next_index),
		.waiting        (waiting),
		.last           (last)
	);

endmodule
`default_nettype wire
